>>> sv/pgfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgfc_pkg - shared definitions for the pitch glide frequency controller
// Formats, constants, config register map and the 2^x interpolation table.
// ----------------------------------------------------------------------------
package pgfc_pkg;

  // fractional octave table: 2^EXP_TABLE_BITS segments, one guard entry
  localparam int EXP_TABLE_BITS = 8;
  localparam int EXP_N          = 1 << EXP_TABLE_BITS;
  localparam int EXP_IDX_W      = EXP_TABLE_BITS + 1;
  localparam int FRAC_W         = 12;                      // remainder against 3072
  localparam int TW             = FRAC_W + EXP_TABLE_BITS;

  localparam int S_TDATA_W = 48;  // note_freq, pitch_mod, zero pad
  localparam int M_TDATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [31:0] RESET_BASE = 32'h001B_8000;  // 440 Hz, Q20.12
  localparam logic [31:0] SNAP_LSB   = 32'd41;         // 0.01 Hz
  localparam int          SEMI_LIMIT = 12288;          // 48 semitones, Q8.8
  localparam int          OCT_Q88    = 3072;           // 12 semitones, Q8.8

  // ceil(2^32 / d): exact floor division for all operands used here
  localparam logic [31:0] RECIP3   = 32'd1431655766;
  localparam logic [31:0] RECIP100 = 32'd42949673;

  // right shift after scaling: 30 - (octave - 4)
  localparam logic [5:0] SH_BASE = 6'd34;

  localparam logic ACT_NOTE_ON = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GLIDE_ENABLE = 3'd0,
    CFG_GLIDE_RATE   = 3'd1,
    CFG_PITCH_OFFSET = 3'd2,
    CFG_FINE_CENTS   = 3'd3,
    CFG_DETUNE_HZ    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        glide_enable;
    logic [23:0] glide_rate;
    logic [14:0] pitch_offset;
    logic [11:0] fine_tune_cents;
    logic [22:0] detune_hz;
  } pgfc_cfg_t;

  typedef logic [31:0] exp_tab_t [0:EXP_N];

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    x   = x_in;
    res = '0;
    bv  = 64'h4000_0000_0000_0000;
    while (bv > x) bv = bv >> 2;
    while (bv != 64'd0) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Q2.30 entries of 2^(i/EXP_N): chained square roots of 2, products rounded
  function automatic exp_tab_t build_exp_tab();
    logic [63:0] root [0:EXP_TABLE_BITS];
    logic [63:0] v;
    exp_tab_t    tab;
    int          k;
    int          i;
    root[0] = 64'd2 << 30;
    for (k = 1; k <= EXP_TABLE_BITS; k++) begin
      root[k] = isqrt64(root[k-1] << 30);
    end
    for (i = 0; i < EXP_N; i++) begin
      v = 64'd1 << 30;
      for (k = 1; k <= EXP_TABLE_BITS; k++) begin
        if (((i >> (EXP_TABLE_BITS - k)) & 1) != 0) begin
          v = (v * root[k] + (64'd1 << 29)) >> 30;
        end
      end
      tab[i] = v[31:0];
    end
    tab[EXP_N] = 32'h8000_0000;
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> sv/pgfc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgfc_mul - shared 32x32 unsigned multiplier
// Product registered once; the sequencer picks operands each cycle.
// ----------------------------------------------------------------------------
module pgfc_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

>>> sv/pgfc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgfc_cfg - configuration register file
// Decodes register writes; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module pgfc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pgfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pgfc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pgfc_pkg::pgfc_cfg_t                 cfg
);
  import pgfc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_GLIDE_ENABLE: cfg.glide_enable    <= cfg_data[0];
        CFG_GLIDE_RATE:   cfg.glide_rate      <= cfg_data[23:0];
        CFG_PITCH_OFFSET: cfg.pitch_offset    <= cfg_data[14:0];
        CFG_FINE_CENTS:   cfg.fine_tune_cents <= cfg_data[11:0];
        CFG_DETUNE_HZ:    cfg.detune_hz       <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/pitch_glide_frequency_control_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_glide_frequency_control_core - oscillator frequency controller
// Portamento glide plus semitone pitch shift, detune and saturation, Q20.12.
// ----------------------------------------------------------------------------
// Usage:
//  s_* stream carries voice events. tuser = action (note_on / tick); tdata
//  holds note_freq and pitch_mod. A note_on transfer sets the target and
//  either arms the glide or snaps the base, and gives no result.
//  A tick runs the glide step and the pitch shift through one shared 32x32
//  multiplier under a sequencer, and s_tready stays low until it returns to
//  ST_IDLE; a glide step adds ST_STEP and ST_APPLY (the snap that ends a
//  glide adds nothing). A tick with a zero target is absorbed in ST_IDLE
//  with no result. The result, if any, loads the output register at the
//  same edge that raises s_tready again.
//  m_tdata is held in an output register, so a stalled receiver only holds
//  the sequencer at its final step when a new result is due while the
//  previous one is still waiting.
//  cfg_* writes registers by index (0 glide_enable .. 4 detune_hz); always
//  ready, intended only while the block is idle.
//  rst (synchronous) clears config, base to 440 Hz, target, glide and the
//  last sent frequency, and drops m_tvalid.
// ----------------------------------------------------------------------------
module pitch_glide_frequency_control_core (
  input  logic                                clk,
  input  logic                                rst,
  // event stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pgfc_pkg::S_TDATA_W-1:0]      s_tdata,   // [31:0] note_freq, [46:32] pitch_mod
  input  logic                                s_tuser,   // [0] action
  // frequency stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pgfc_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] osc_freq
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pgfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pgfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pgfc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_STEP, ST_APPLY, ST_FINE, ST_SUM, ST_OCT, ST_REM,
    ST_IDX, ST_FRAC, ST_INTERP, ST_IMUL, ST_IRND, ST_IDIV, ST_MULT,
    ST_SCALE, ST_ROUND, ST_SHIFT, ST_EMIT
  } state_t;

  pgfc_cfg_t cfg;
  state_t    state;

  // voice state
  logic [31:0] base;
  logic [31:0] target;
  logic        gliding;
  logic [31:0] last_sent;
  logic        moved;

  // working registers
  logic [14:0]               pmod;
  logic [31:0]               dmag;
  logic                      dneg;
  logic [31:0]               step;
  logic [19:0]               fine_x;
  logic [14:0]               oct_u;
  logic [3:0]                oct_q;
  logic [FRAC_W-1:0]         rem;
  logic [EXP_TABLE_BITS-1:0] idx;
  logic [FRAC_W-1:0]         fr;
  logic [31:0]               e0;
  logic [31:0]               diff;
  logic [31:0]               y;
  logic [31:0]               mult;
  logic [63:0]               rsum;
  logic [31:0]               res;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  pgfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pgfc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // --- combinational helpers ---
  logic [32:0]               d_full;
  logic [11:0]               cmag;
  logic [12:0]               fq;
  logic signed [17:0]        fine_s;
  logic signed [17:0]        s_sum;
  logic signed [17:0]        s_cl;
  logic [TW-1:0]             t;
  logic [EXP_TABLE_BITS-1:0] idx_n;
  logic [EXP_IDX_W-1:0]      idx_lo;
  logic [EXP_IDX_W-1:0]      idx_hi;
  logic [63:0]               step_rnd;
  logic [63:0]               i_rnd;
  logic [5:0]                sh;
  logic [63:0]               shv;
  logic signed [39:0]        fsum;
  logic signed [32:0]        dd;
  logic                      out_big;
  logic                      emit_load;

  assign s_tready = (state == ST_IDLE);

  assign d_full = {1'b0, target} - {1'b0, base};
  assign cmag   = cfg.fine_tune_cents[11] ? 12'(-cfg.fine_tune_cents) : cfg.fine_tune_cents;

  // fine tune in Q8.8: round(cents * 256 / 100), halves away from zero
  assign fq     = prod[44:32];
  assign fine_s = cfg.fine_tune_cents[11] ? -$signed({5'b0, fq}) : $signed({5'b0, fq});
  assign s_sum  = 18'($signed(cfg.pitch_offset)) + 18'($signed(pmod)) + fine_s;

  always_comb begin
    priority if (s_sum > 18'sd12288) begin
      s_cl = 18'(SEMI_LIMIT);
    end else if (s_sum < -18'sd12288) begin
      s_cl = -18'(SEMI_LIMIT);
    end else begin
      s_cl = s_sum;
    end
  end

  // table position: remainder scaled to EXP_N segments of 3072
  assign t      = {rem, {EXP_TABLE_BITS{1'b0}}};
  assign idx_n  = prod[32 +: EXP_TABLE_BITS];
  assign idx_lo = EXP_IDX_W'(idx);
  assign idx_hi = idx_lo + 1'b1;

  assign step_rnd = prod + 64'h0080_0000;
  assign i_rnd    = prod + 64'd1536;
  assign sh       = SH_BASE - 6'(oct_q);
  assign shv      = rsum >> sh;
  assign fsum     = $signed({2'b0, shv[37:0]}) + 40'($signed(cfg.detune_hz));

  assign dd      = $signed({1'b0, res}) - $signed({1'b0, last_sent});
  assign out_big = (dd >= 33'sd41) || (dd <= -33'sd41);

  // result due and the output register free (or emptied at this edge)
  assign emit_load = (state == ST_EMIT) && (moved || out_big) && (!m_tvalid || m_tready);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_DIFF: begin
        mul_a = dmag;
        mul_b = 32'(cfg.glide_rate);
      end
      ST_FINE: begin
        mul_a = 32'(fine_x);
        mul_b = RECIP100;
      end
      ST_OCT: begin
        mul_a = 32'(oct_u[14:10]);
        mul_b = RECIP3;
      end
      ST_IDX: begin
        mul_a = 32'(t[TW-1:10]);
        mul_b = RECIP3;
      end
      ST_IMUL: begin
        mul_a = diff;
        mul_b = 32'(fr);
      end
      ST_IDIV: begin
        mul_a = y;
        mul_b = RECIP3;
      end
      ST_SCALE: begin
        mul_a = base;
        mul_b = mult;
      end
      default: ;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      base      <= RESET_BASE;
      target    <= '0;
      gliding   <= 1'b0;
      last_sent <= '0;
      moved     <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == ACT_NOTE_ON) begin
              target <= s_tdata[31:0];
              if (cfg.glide_enable && (cfg.glide_rate != 24'd0)) begin
                gliding <= 1'b1;
              end else begin
                base    <= s_tdata[31:0];
                gliding <= 1'b0;
              end
            end else if (target != 32'd0) begin
              pmod  <= s_tdata[46:32];
              dneg  <= d_full[32];
              dmag  <= d_full[32] ? 32'(-d_full) : d_full[31:0];
              moved <= 1'b0;
              state <= ST_DIFF;
            end
          end
        end
        ST_DIFF: begin
          fine_x <= {cmag, 8'b0} + 20'd50;
          if (gliding) begin
            if (dmag < SNAP_LSB) begin
              base    <= target;
              gliding <= 1'b0;
              moved   <= 1'b1;
              state   <= ST_FINE;
            end else begin
              state <= ST_STEP;   // |d| * rate in flight
            end
          end else begin
            if (dmag >= SNAP_LSB) begin
              base  <= target;
              moved <= 1'b1;
            end
            state <= ST_FINE;
          end
        end
        ST_STEP: begin
          step  <= step_rnd[55:24];
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          base  <= dneg ? (base - step) : (base + step);
          moved <= 1'b1;
          state <= ST_FINE;
        end
        ST_FINE: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          oct_u <= 15'(s_cl + 18'(SEMI_LIMIT));
          state <= ST_OCT;
        end
        ST_OCT: begin
          state <= ST_REM;
        end
        ST_REM: begin
          oct_q <= prod[35:32];
          rem   <= FRAC_W'(oct_u - 15'(prod[35:32]) * 15'(OCT_Q88));
          state <= ST_IDX;
        end
        ST_IDX: begin
          state <= ST_FRAC;
        end
        ST_FRAC: begin
          idx   <= idx_n;
          fr    <= FRAC_W'(t - TW'(idx_n) * TW'(OCT_Q88));
          state <= ST_INTERP;
        end
        ST_INTERP: begin
          e0    <= EXP_TAB[idx_lo];
          diff  <= EXP_TAB[idx_hi] - EXP_TAB[idx_lo];
          state <= ST_IMUL;
        end
        ST_IMUL: begin
          state <= ST_IRND;
        end
        ST_IRND: begin
          y     <= i_rnd[41:10];
          state <= ST_IDIV;
        end
        ST_IDIV: begin
          state <= ST_MULT;
        end
        ST_MULT: begin
          mult  <= e0 + prod[63:32];
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rsum  <= prod + (64'd1 << (sh - 6'd1));
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          priority if (fsum < 40'sd0) begin
            res <= '0;
          end else if (fsum > 40'sh00_FFFF_FFFF) begin
            res <= 32'hFFFF_FFFF;
          end else begin
            res <= fsum[31:0];
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // wait here only while the previous result is still unclaimed
          if (emit_load) begin
            m_tdata   <= res;
            last_sent <= res;
            state     <= ST_IDLE;
          end else if (!(moved || out_big)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_out_is_last_sent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == last_sent))
    else $error("pending result differs from last sent frequency");

  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == ACT_TICK) && (target != 32'd0))
      |=> (state == ST_DIFF))
    else $error("tick with live target did not start the sequence");

  a_octave_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDX) |-> (oct_q <= 4'd8))
    else $error("octave quotient out of range");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INTERP) |-> (fr < FRAC_W'(OCT_Q88)))
    else $error("interpolation fraction out of range");

  a_base_idle_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && !s_tvalid) |=> (base == $past(base)))
    else $error("base frequency moved without a transfer");
`endif

endmodule

>>> verif/pgfc_osc_freq_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgfc_osc_freq_monitor - oscillator frequency tracker for the glide core
// Watches the event, frequency and register channels. It keeps its own copy
// of the tuning registers and the voice state, works out each osc_freq that
// a tick is due to emit, and compares every frequency transfer in order.
// ----------------------------------------------------------------------------
module pgfc_osc_freq_monitor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [pgfc_pkg::S_TDATA_W-1:0]  s_tdata,   // [31:0] note_freq, [46:32] pitch_mod
  input  logic                            s_tuser,   // [0] action
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [pgfc_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] osc_freq
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pgfc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pgfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              freq_pending
);
  import pgfc_pkg::*;

  localparam longint SNAP   = SNAP_LSB;
  localparam longint HZ_MAX = 64'h0000_0000_FFFF_FFFF;

  logic [31:0] pow2_frac [0:EXP_N];

  logic        reg_glide_en;
  logic [23:0] reg_rate;
  logic [14:0] reg_offset;
  logic [11:0] reg_cents;
  logic [22:0] reg_detune;

  logic [31:0] base_hz;
  logic [31:0] target_hz;
  logic [31:0] last_hz;
  logic        in_glide;

  logic [31:0] osc_freq_due [$];
  logic [31:0] due;

  // 2^(i/EXP_N) in Q2.30 from chained square roots of two
  initial begin : build_pow2
    logic [63:0] chain [0:EXP_TABLE_BITS];
    logic [63:0] rad;
    logic [63:0] acc;
    logic [63:0] bitv;
    logic [63:0] v;
    int          k;
    int          i;
    chain[0] = 64'd2 << 30;
    for (k = 1; k <= EXP_TABLE_BITS; k++) begin
      rad  = chain[k-1] << 30;
      acc  = '0;
      bitv = 64'd1 << 62;
      while (bitv > rad) bitv = bitv >> 2;
      while (bitv != 64'd0) begin
        if (rad >= acc + bitv) begin
          rad = rad - (acc + bitv);
          acc = (acc >> 1) + bitv;
        end else begin
          acc = acc >> 1;
        end
        bitv = bitv >> 2;
      end
      chain[k] = acc;
    end
    for (i = 0; i < EXP_N; i++) begin
      v = 64'd1 << 30;
      for (k = 1; k <= EXP_TABLE_BITS; k++) begin
        if (((i >> (EXP_TABLE_BITS - k)) & 1) != 0) begin
          v = (v * chain[k] + (64'd1 << 29)) >> 30;
        end
      end
      pow2_frac[i] = v[31:0];
    end
    pow2_frac[EXP_N] = 32'h8000_0000;
  end

  // nearest, halves away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // one control-rate update: glide step, pitch shift, detune, emit decision
  task automatic voice_tick(input logic [14:0] mod);
    logic        moved;
    longint      tgt;
    longint      bse;
    longint      rate;
    longint      gap;
    longint      step;
    longint      shift;
    longint      oct_u;
    longint      oct;
    longint      rem;
    longint      seg;
    longint      frac;
    longint      hz;
    longint      sent_hz;
    longint      dt;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mult;
    logic [63:0] prod;
    int          sh;
    if (target_hz == 32'd0) return;
    moved = 1'b0;
    tgt   = target_hz;
    bse   = base_hz;
    rate  = reg_rate;
    gap   = tgt - bse;
    if (in_glide) begin
      if (gap > -SNAP && gap < SNAP) begin
        base_hz  = target_hz;
        in_glide = 1'b0;
      end else begin
        step    = round_div(gap * rate, 64'd1 << 24);
        hz      = bse + step;
        base_hz = hz[31:0];
      end
      moved = 1'b1;
    end else if (gap >= SNAP || gap <= -SNAP) begin
      base_hz = target_hz;
      moved   = 1'b1;
    end

    shift = $signed(reg_offset) + $signed(mod) + round_div($signed(reg_cents) * 256, 100);
    if (shift > SEMI_LIMIT) shift = SEMI_LIMIT;
    if (shift < -SEMI_LIMIT) shift = -SEMI_LIMIT;

    oct_u = shift + SEMI_LIMIT;
    oct   = oct_u / OCT_Q88 - 4;
    rem   = oct_u % OCT_Q88;
    seg   = (rem * EXP_N) / OCT_Q88;
    frac  = (rem * EXP_N) % OCT_Q88;
    lo    = pow2_frac[seg];
    hi    = pow2_frac[seg + 1];
    mult  = lo + ((hi - lo) * frac + OCT_Q88 / 2) / OCT_Q88;

    prod = {32'd0, base_hz} * mult;
    sh   = 30 - oct;
    hz   = (prod + (64'd1 << (sh - 1))) >> sh;
    dt   = $signed(reg_detune);
    hz   = hz + dt;
    if (hz < 0) hz = 0;
    if (hz > HZ_MAX) hz = HZ_MAX;

    sent_hz = last_hz;
    gap     = hz - sent_hz;
    if (moved || gap >= SNAP || gap <= -SNAP) begin
      last_hz = hz[31:0];
      osc_freq_due.push_back(hz[31:0]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reg_glide_en = 1'b0;
      reg_rate     = '0;
      reg_offset   = '0;
      reg_cents    = '0;
      reg_detune   = '0;
      base_hz      = RESET_BASE;
      target_hz    = '0;
      last_hz      = '0;
      in_glide     = 1'b0;
      mismatches   = 0;
      osc_freq_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (osc_freq_due.size() == 0) begin
          $display("%0t: osc_freq expected none, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          due = osc_freq_due.pop_front();
          if (m_tdata !== due) begin
            $display("%0t: osc_freq expected %h, actual %h", $time, due, m_tdata);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          CFG_GLIDE_ENABLE: reg_glide_en = cfg_data[0];
          CFG_GLIDE_RATE:   reg_rate     = cfg_data[23:0];
          CFG_PITCH_OFFSET: reg_offset   = cfg_data[14:0];
          CFG_FINE_CENTS:   reg_cents    = cfg_data[11:0];
          CFG_DETUNE_HZ:    reg_detune   = cfg_data[22:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == ACT_NOTE_ON) begin
          target_hz = s_tdata[31:0];
          if (reg_glide_en && reg_rate != 24'd0) begin
            in_glide = 1'b1;
          end else begin
            base_hz  = target_hz;
            in_glide = 1'b0;
          end
        end else begin
          voice_tick(s_tdata[46:32]);
        end
      end
    end
    freq_pending = osc_freq_due.size();
  end

endmodule

>>> verif/pitch_glide_frequency_control_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_glide_frequency_control_core_tb - stimulus and verdict for the core
// Drives voice events and register writes with random idle gaps and
// receiver stalls; the frequency monitor beside the core tracks and checks
// every osc_freq transfer. Directed corner events come first, then several
// tuning phases of random note/tick sequences.
// ----------------------------------------------------------------------------
module pitch_glide_frequency_control_core_tb;
  import pgfc_pkg::*;

  localparam int CLK_HALF      = 6;       // 12 ns period
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 40;      // covers a tick still in the sequencer plus the output reg
  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
  localparam int PHASE_ITEMS   = 75;      // eight random phases, ~600 events

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;    // [31:0] note_freq, [46:32] pitch_mod
  logic                  s_tuser  = 1'b0;  // [0] action

  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;          // [31:0] osc_freq

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int                    mismatches;
  int                    freq_pending;
  int                    cycles = 0;
  bit                    steady = 1'b0;   // set: neither side idles
  int                    ph;

  always #(CLK_HALF) clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pitch_glide_frequency_control_core verification failed");
      $finish;
    end
  end

  pitch_glide_frequency_control_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  pgfc_osc_freq_monitor i_freq_mon (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .freq_pending (freq_pending)
  );

  // Frequency sink: per transfer a random stall (none when steady), then ready held
  // until the transfer lands. Ready is only ever set once per falling edge.
  initial begin : freq_sink
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // One event transfer. Valid stays high from the previous transfer when
  // there is no gap, so it is never dropped and raised in the same step.
  // During a gap the data lines carry noise.
  task automatic send_event(input logic act, input logic [31:0] freq,
                            input logic [14:0] mod);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {1'b0, 15'($urandom), $urandom};
      s_tuser  <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, mod, freq};
    do @(posedge clk); while (!s_tready);
  endtask

  // drop valid before any pause in the event stream
  task automatic pause_events();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // bits outside the register width are filled with noise
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val,
                           input logic [CFG_DATA_W-1:0] keep);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= (val & keep) | (CFG_DATA_W'($urandom) & ~keep);
    do @(posedge clk); while (!cfg_ready);
  endtask

  // New tuning set, only once the core has gone quiet: all expected
  // frequencies in, then time for a silent tick still in the sequencer.
  task automatic retune(input logic ge, input logic [23:0] rate,
                        input logic [14:0] off, input logic [11:0] cents,
                        input logic [22:0] det);
    pause_events();
    while (freq_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_GLIDE_ENABLE, {23'd0, ge}, 24'h00_0001);
    write_reg(CFG_GLIDE_RATE,   rate,        24'hFF_FFFF);
    write_reg(CFG_PITCH_OFFSET, {9'd0, off}, 24'h00_7FFF);
    write_reg(CFG_FINE_CENTS,   {12'd0, cents}, 24'h00_0FFF);
    write_reg(CFG_DETUNE_HZ,    {1'd0, det}, 24'h7F_FFFF);
    write_reg(CFG_ADDR_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom), 24'h0);  // unmapped
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly note_on followed by a run of ticks with vibrato-like modulation;
  // the rest is lone events with arbitrary content.
  task automatic play_phrases(input int count);
    int          n;
    int          ticks;
    int          k;
    logic [31:0] hz;
    logic [14:0] mod;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 19) == 0) steady = ~steady;
      // hold the stream until every frequency is out
      if ($urandom_range(0, 49) == 0) begin
        pause_events();
        while (freq_pending != 0) @(negedge clk);
      end
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 9))
          0:       hz = $urandom;
          1:       hz = 32'hFFFF_FFFF;
          2:       hz = $urandom_range(0, 200);              // zero and sub-Hz targets
          default: hz = $urandom_range(81920, 81920000);     // 20 Hz .. 20 kHz
        endcase
        send_event(ACT_NOTE_ON, hz, 15'($urandom));
        ticks = $urandom_range(1, 12);
        for (k = 0; k < ticks; k++) begin
          case ($urandom_range(0, 9))
            0:       mod = '0;                                      // repeats stay silent
            1:       mod = 15'($urandom);                           // any, clamp
            2, 3:    mod = 15'($urandom_range(0, 24576) - 12288);   // full legal range
            default: mod = 15'($urandom_range(0, 1024) - 512);      // +-2 semitones
          endcase
          send_event(ACT_TICK, $urandom, mod);
        end
        n += 1 + ticks;
      end else begin
        send_event(1'($urandom), $urandom, 15'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed, reset tuning ---
    send_event(ACT_TICK,    32'h1234_5678, 15'd0);     // zero target: silent
    send_event(ACT_NOTE_ON, 32'hFFFF_FFFF, 15'h7FFF);
    send_event(ACT_TICK,    32'd0,         15'd12288); // +48 st, saturates
    send_event(ACT_TICK,    32'd0,         15'h5000);  // -48 st
    send_event(ACT_TICK,    32'd0,         15'h3FFF);  // over range, clamped
    send_event(ACT_TICK,    32'd0,         15'h4000);  // under range, clamped
    send_event(ACT_TICK,    32'd0,         15'h4000);  // no change: silent
    send_event(ACT_NOTE_ON, 32'd0,         15'd0);
    send_event(ACT_TICK,    32'd0,         15'd300);   // zero target again
    send_event(ACT_NOTE_ON, RESET_BASE,    15'd0);
    send_event(ACT_TICK,    32'd0,         15'd0);
    send_event(ACT_TICK,    32'd0,         15'd0);     // same frequency: silent
    send_event(ACT_TICK,    32'd0,         15'd1);     // one Q8.8 step
    send_event(ACT_NOTE_ON, 32'd1,         15'd0);     // smallest target
    send_event(ACT_TICK,    32'd0,         15'h5000);  // scales to zero
    send_event(ACT_NOTE_ON, 32'd41,        15'd0);
    send_event(ACT_TICK,    32'd0,         15'd0);

    // --- directed, glide at full rate, top of every tuning range ---
    retune(1'b1, 24'hFF_FFFF, 15'd12288, 12'd1200, 23'h3F_FFFF);
    send_event(ACT_NOTE_ON, 32'd81920,     15'd0);
    send_event(ACT_TICK,    32'd0,         15'd0);
    send_event(ACT_TICK,    32'd0,         15'd0);
    send_event(ACT_TICK,    32'd0,         15'd0);     // glide already ended: silent
    send_event(ACT_NOTE_ON, 32'hFFFF_FFFF, 15'd0);
    send_event(ACT_TICK,    32'd0,         15'h5000);
    send_event(ACT_TICK,    32'd0,         15'h5000);
    play_phrases(PHASE_ITEMS);

    // slowest glide, bottom of every tuning range
    retune(1'b1, 24'd1, 15'h5000, 12'hB50, 23'h40_0000);
    play_phrases(PHASE_ITEMS);

    // glide enabled but zero rate: notes snap
    retune(1'b1, 24'd0, 15'd0, 12'd0, 23'd0);
    play_phrases(PHASE_ITEMS);

    // glide off, out-of-range pitch offset and fine tune at the field limits
    retune(1'b0, 24'h80_0000, 15'h3FFF, 12'h800, 23'h00_1000);
    play_phrases(PHASE_ITEMS);

    // random tuning sets, glide on more often than not
    for (ph = 0; ph < 4; ph++) begin
      retune(($urandom_range(0, 3) != 0), 24'($urandom_range(1, 24'hFF_FFFF)),
             15'($urandom), 12'($urandom), 23'($urandom));
      play_phrases(PHASE_ITEMS);
    end

    // drain and verdict
    pause_events();
    while (freq_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && freq_pending == 0) begin
      $display("pitch_glide_frequency_control_core verification clean");
    end else begin
      $display("pitch_glide_frequency_control_core verification failed");
    end
    $finish;
  end

endmodule

>>> pitch_glide_frequency_control_core.f
sv/pgfc_pkg.sv
sv/pgfc_mul.sv
sv/pgfc_cfg.sv
sv/pitch_glide_frequency_control_core.sv
verif/pgfc_osc_freq_monitor.sv
verif/pitch_glide_frequency_control_core_tb.sv
